[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted
`define MPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge
`define MPQ_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[design/mpq_pkg.sv]
`timescale 1ns / 1ps

package mpq_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = 7;
	localparam int VAL_W  = 32;
	localparam int PRIO_W = 8;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_PEEK   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]              func;
		logic signed [VAL_W-1:0] item_value;
		logic [PRIO_W-1:0]       item_priority;
	} mpq_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] out_value;
		logic [1:0]              status;
		logic [CNT_W-1:0]        entry_count;
	} mpq_rsp_t;

	typedef struct packed {
		logic req_load;
		logic ins_write;
		logic scan_start;
		logic shift_start;
		logic sweep_run;
		logic cnt_dec;
		logic rsp_load;
	} mpq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic sweep_done;
	} mpq_stat_t;

endpackage

[design/mpq_datapath.sv]
`timescale 1ns / 1ps

module mpq_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  mpq_pkg::mpq_req_t  req,
	input  mpq_pkg::mpq_cmd_t  cmd,
	output mpq_pkg::mpq_stat_t stat,
	output mpq_pkg::mpq_rsp_t  rsp
);
	import mpq_pkg::*;

	logic [VAL_W-1:0]  vals_mem  [DEPTH];
	logic [PRIO_W-1:0] prios_mem [DEPTH];

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              shift_mode_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [VAL_W-1:0]  rd_val_s1;
	logic [PRIO_W-1:0] rd_prio_s1;
	logic              best_vld_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [PRIO_W-1:0] best_prio_q;
	logic [VAL_W-1:0]  best_val_q;
	logic [1:0]        func_q;
	logic [1:0]        st_q;
	mpq_rsp_t          rsp_q;
	logic              issue;
	logic              take_best;
	logic              shift_wr;
	logic [IDX_W-1:0]  shift_addr;
	mpq_rsp_t          rsp_d;

	assign issue      = cmd.sweep_run && (ptr_q < cnt_q);
	assign take_best  = rd_vld_s1 && !shift_mode_q &&
	                    (!best_vld_q || (rd_prio_s1 > best_prio_q));
	assign shift_wr   = rd_vld_s1 && shift_mode_q;
	assign shift_addr = rd_idx_s1 - IDX_W'(1);

	assign stat.full       = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty      = (cnt_q == '0);
	assign stat.sweep_done = (ptr_q >= cnt_q) && !rd_vld_s1;

	// storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			vals_mem[cnt_q[IDX_W-1:0]]  <= req.item_value;
			prios_mem[cnt_q[IDX_W-1:0]] <= req.item_priority;
		end else if (shift_wr) begin
			vals_mem[shift_addr]  <= rd_val_s1;
			prios_mem[shift_addr] <= rd_prio_s1;
		end
		if (issue) begin
			rd_val_s1  <= vals_mem[ptr_q[IDX_W-1:0]];
			rd_prio_s1 <= prios_mem[ptr_q[IDX_W-1:0]];
			rd_idx_s1  <= ptr_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			ptr_q        <= '0;
			shift_mode_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			best_vld_q   <= 1'b0;
		end else begin
			if (cmd.ins_write)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (cmd.cnt_dec)
				cnt_q <= cnt_q - CNT_W'(1);

			if (cmd.scan_start) begin
				ptr_q        <= '0;
				shift_mode_q <= 1'b0;
			end else if (cmd.shift_start) begin
				// closing the gap: entry k+1 onwards moves down by one
				ptr_q        <= CNT_W'(best_idx_q) + CNT_W'(1);
				shift_mode_q <= 1'b1;
			end else if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end

			rd_vld_s1 <= issue;

			if (cmd.scan_start)
				best_vld_q <= 1'b0;
			else if (take_best)
				best_vld_q <= 1'b1;
		end
	end

	// strict compare keeps the oldest entry on a tie
	always_ff @(posedge clk) begin
		if (take_best) begin
			best_idx_q  <= rd_idx_s1;
			best_prio_q <= rd_prio_s1;
			best_val_q  <= rd_val_s1;
		end
		if (cmd.req_load) begin
			func_q <= req.func;
			if (req.func == FUNC_INSERT && stat.full)
				st_q <= ST_FULL;
			else if ((req.func == FUNC_REMOVE || req.func == FUNC_PEEK) && stat.empty)
				st_q <= ST_EMPTY;
			else
				st_q <= ST_OK;
		end
		if (cmd.rsp_load)
			rsp_q <= rsp_d;
	end

	always_comb begin
		rsp_d.status      = st_q;
		rsp_d.entry_count = cnt_q;
		if (st_q == ST_OK && (func_q == FUNC_REMOVE || func_q == FUNC_PEEK))
			rsp_d.out_value = best_val_q;
		else
			rsp_d.out_value = '0;
	end

	assign rsp = rsp_q;

endmodule

[design/mpq_ctrl.sv]
`timescale 1ns / 1ps

module mpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         req_func,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  mpq_pkg::mpq_stat_t stat,
	output mpq_pkg::mpq_cmd_t  cmd
);
	import mpq_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [1:0] func_q;
	logic       rsp_valid_q;
	logic       accept;
	logic       out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.req_load = 1'b1;
					state_d      = S_DONE;
					if (req_func == FUNC_INSERT) begin
						cmd.ins_write = !stat.full;
					end else if ((req_func == FUNC_REMOVE || req_func == FUNC_PEEK)
					             && !stat.empty) begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.sweep_run = 1'b1;
				if (stat.sweep_done) begin
					if (func_q == FUNC_REMOVE) begin
						cmd.shift_start = 1'b1;
						state_d         = S_SHIFT;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SHIFT: begin
				cmd.sweep_run = 1'b1;
				if (stat.sweep_done) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			func_q      <= FUNC_INSERT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				func_q <= req_func;
			if (cmd.rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

[design/max_priority_queue.sv]
`timescale 1ns / 1ps
// beat      | handshake             | payload
// request   | req_valid / req_ready | req : func, item_value, item_priority
// response  | rsp_valid / rsp_ready | rsp : out_value, status, entry_count
//
// Insert, an error or an unused func: the done state follows accept and loads the response.
// Peek scans the n entries held to find the best; remove then closes up the m entries behind
// the best, moving each down by one; one entry read per cycle in each pass.
// Reset clears the count, pointers and valid flags; no clearing pass over the entry store.
// A request is taken while the previous response still waits; the response
// register holds under rsp_ready low and the next one waits behind it.
module max_priority_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  mpq_pkg::mpq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output mpq_pkg::mpq_rsp_t rsp
);
	import mpq_pkg::*;

	`include "assert_macros.svh"

	mpq_cmd_t  cmd;
	mpq_stat_t stat;

	mpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_func  (req.func),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mpq_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

	`MPQ_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready, "accepted while busy")
	`MPQ_ASSERT(a_full_count, (rsp_valid && rsp.status == ST_FULL) |-> (rsp.entry_count == CNT_W'(DEPTH)), "full reported below depth")
	`MPQ_ASSERT(a_empty_resp, (rsp_valid && rsp.status == ST_EMPTY) |-> (rsp.entry_count == '0 && rsp.out_value == '0), "empty response not clean")
	`MPQ_NEVER(a_ins_when_full, cmd.ins_write && stat.full, "write past end of store")

endmodule
